[rtl/vmrt_pkg.sv]
package vmrt_pkg;

	// register window
	localparam int unsigned WINDOW_BYTES = 512;
	localparam int unsigned OFF_W = 9;
	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(WINDOW_BYTES - 4);

	localparam logic [31:0] MAGIC_VALUE = 32'h7472_6976;
	localparam logic [31:0] VERSION_MODERN = 32'd2;
	localparam logic [3:0] ACCESS_LEN = 4'd4;

	// functions of an access
	localparam logic [1:0] FN_READ = 2'd0;
	localparam logic [1:0] FN_WRITE = 2'd1;
	localparam logic [1:0] FN_DONE = 2'd2;

	// device status bits
	localparam int unsigned ST_ACK = 0;
	localparam int unsigned ST_DRIVER = 1;
	localparam int unsigned ST_DRV_LIVE = 2;
	localparam int unsigned ST_FEAT_AGREED = 3;
	localparam logic [3:0] ST_ALL = 4'hf;

	// register offsets
	localparam logic [OFF_W-1:0] R_MAGIC = 9'h000;
	localparam logic [OFF_W-1:0] R_VERSION = 9'h004;
	localparam logic [OFF_W-1:0] R_DEVICE_ID = 9'h008;
	localparam logic [OFF_W-1:0] R_VENDOR_ID = 9'h00c;
	localparam logic [OFF_W-1:0] R_DEV_FEAT = 9'h010;
	localparam logic [OFF_W-1:0] R_DEV_FEAT_SEL = 9'h014;
	localparam logic [OFF_W-1:0] R_DRV_FEAT = 9'h020;
	localparam logic [OFF_W-1:0] R_DRV_FEAT_SEL = 9'h024;
	localparam logic [OFF_W-1:0] R_QUEUE_SEL = 9'h030;
	localparam logic [OFF_W-1:0] R_QUEUE_MAX = 9'h034;
	localparam logic [OFF_W-1:0] R_QUEUE_SIZE = 9'h038;
	localparam logic [OFF_W-1:0] R_QUEUE_READY = 9'h044;
	localparam logic [OFF_W-1:0] R_QUEUE_NOTIFY = 9'h050;
	localparam logic [OFF_W-1:0] R_INT_STATUS = 9'h060;
	localparam logic [OFF_W-1:0] R_INT_ACK = 9'h064;
	localparam logic [OFF_W-1:0] R_STATUS = 9'h070;
	localparam logic [OFF_W-1:0] R_DESC_LO = 9'h080;
	localparam logic [OFF_W-1:0] R_DESC_HI = 9'h084;
	localparam logic [OFF_W-1:0] R_DRV_LO = 9'h090;
	localparam logic [OFF_W-1:0] R_DRV_HI = 9'h094;
	localparam logic [OFF_W-1:0] R_DEV_LO = 9'h0a0;
	localparam logic [OFF_W-1:0] R_DEV_HI = 9'h0a4;

	// error codes
	localparam logic [2:0] E_OK = 3'd0;
	localparam logic [2:0] E_ACCESS = 3'd1;
	localparam logic [2:0] E_DIR = 3'd2;
	localparam logic [2:0] E_UNIMPL = 3'd3;
	localparam logic [2:0] E_REJECT = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DESC_ADDR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_ADDR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_USED_ADDR = 3'd5;

	typedef struct packed {
		logic [1:0]       func;
		logic [OFF_W-1:0] offset;
		logic [3:0]       access_bytes;
		logic [31:0]      write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [2:0]  error_code;
		logic        notify_kick;
	} rsp_t;

	typedef struct packed {
		logic [31:0] device_id;
		logic [31:0] vendor_id;
		logic [15:0] queue_size_required;
		logic [63:0] desc_ring_addr;
		logic [63:0] avail_ring_addr;
		logic [63:0] used_ring_addr;
	} cfg_t;

endpackage

[rtl/vmrt_if.sv]
interface vmrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [8:0]  offset;
	logic [3:0]  access_bytes;
	logic [31:0] write_data;

	modport source (output valid, func, offset, access_bytes, write_data, input ready);
	modport sink (input valid, func, offset, access_bytes, write_data, output ready);
endinterface

interface vmrt_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [2:0]  error_code;
	logic        notify_kick;

	modport source (output valid, read_data, error_code, notify_kick, input ready);
	modport sink (input valid, read_data, error_code, notify_kick, output ready);
endinterface

[rtl/vmrt_cfg.sv]
module vmrt_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vmrt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vmrt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output vmrt_pkg::cfg_t                    cfg
);

	vmrt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id <= 32'd4;
			cfg_q.vendor_id <= 32'd0;
			cfg_q.queue_size_required <= 16'd8;
			cfg_q.desc_ring_addr <= 64'h4000;
			cfg_q.avail_ring_addr <= 64'h5000;
			cfg_q.used_ring_addr <= 64'h6000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vmrt_pkg::CFG_DEVICE_ID:  cfg_q.device_id <= cfg_wdata[31:0];
				vmrt_pkg::CFG_VENDOR_ID:  cfg_q.vendor_id <= cfg_wdata[31:0];
				vmrt_pkg::CFG_QUEUE_SIZE: cfg_q.queue_size_required <= cfg_wdata[15:0];
				vmrt_pkg::CFG_DESC_ADDR:  cfg_q.desc_ring_addr <= cfg_wdata;
				vmrt_pkg::CFG_AVAIL_ADDR: cfg_q.avail_ring_addr <= cfg_wdata;
				vmrt_pkg::CFG_USED_ADDR:  cfg_q.used_ring_addr <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/vmrt_req_stage.sv]
module vmrt_req_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vmrt_pkg::req_t  in_data,
	input  logic            advance,
	output logic            valid_s1,
	output vmrt_pkg::req_t  req_s1
);

	logic vld_s1;

	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
	end

	assign valid_s1 = vld_s1;

endmodule

[rtl/vmrt_core.sv]
module vmrt_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  vmrt_pkg::req_t  req,
	input  vmrt_pkg::cfg_t  cfg,
	output vmrt_pkg::rsp_t  rsp
);

	// narrowed device state: selectors and feature words kept as the flags they feed
	logic [3:0]  status_q, status_d;
	logic        dfs_one_q, dfs_one_d;       // device feature select == 1
	logic        dsel_ge2_q, dsel_ge2_d;     // driver feature select >= 2
	logic        dsel_b0_q, dsel_b0_d;
	logic        w0_zero_q, w0_zero_d;       // driver feature word 0 == 0
	logic        w1_one_q, w1_one_d;         // driver feature word 1 == 1
	logic        qsel_nz_q, qsel_nz_d;
	logic [15:0] qsize_q, qsize_d;
	logic        qready_q, qready_d;
	logic [63:0] desc_q, desc_d;
	logic [63:0] avail_q, avail_d;
	logic [63:0] used_q, used_d;
	logic        irq_q, irq_d;

	logic        layout_ok;
	logic        qlock;
	logic        bad_access;
	logic        fo_fail;
	logic [3:0]  st_acc;
	logic [31:0] v;
	logic [vmrt_pkg::OFF_W-1:0] off;
	logic        hi;

	assign v = req.write_data;
	assign off = req.offset;
	assign hi = off[2];
	assign layout_ok = (qsize_q == cfg.queue_size_required) &&
		(desc_q == cfg.desc_ring_addr) && (avail_q == cfg.avail_ring_addr) &&
		(used_q == cfg.used_ring_addr);
	assign qlock = qsel_nz_q || qready_q;
	assign bad_access = (req.access_bytes != vmrt_pkg::ACCESS_LEN) || (off[1:0] != 2'b00) ||
		(off > vmrt_pkg::OFF_LAST);
	assign fo_fail = !((v[vmrt_pkg::ST_ACK] && v[vmrt_pkg::ST_DRIVER]) && w0_zero_q && w1_one_q);

	always_comb begin
		status_d = status_q;
		dfs_one_d = dfs_one_q;
		dsel_ge2_d = dsel_ge2_q;
		dsel_b0_d = dsel_b0_q;
		w0_zero_d = w0_zero_q;
		w1_one_d = w1_one_q;
		qsel_nz_d = qsel_nz_q;
		qsize_d = qsize_q;
		qready_d = qready_q;
		desc_d = desc_q;
		avail_d = avail_q;
		used_d = used_q;
		irq_d = irq_q;
		st_acc = v[3:0];
		rsp = '0;
		rsp.error_code = vmrt_pkg::E_OK;

		if (req.func == vmrt_pkg::FN_DONE) begin
			irq_d = 1'b1;
		end else if (req.func != vmrt_pkg::FN_READ && req.func != vmrt_pkg::FN_WRITE) begin
			rsp.error_code = vmrt_pkg::E_DIR;
		end else if (bad_access) begin
			rsp.error_code = vmrt_pkg::E_ACCESS;
		end else if (req.func == vmrt_pkg::FN_READ) begin
			unique case (off) inside
				vmrt_pkg::R_MAGIC:       rsp.read_data = vmrt_pkg::MAGIC_VALUE;
				vmrt_pkg::R_VERSION:     rsp.read_data = vmrt_pkg::VERSION_MODERN;
				vmrt_pkg::R_DEVICE_ID:   rsp.read_data = cfg.device_id;
				vmrt_pkg::R_VENDOR_ID:   rsp.read_data = cfg.vendor_id;
				vmrt_pkg::R_DEV_FEAT:    rsp.read_data = {31'd0, dfs_one_q};
				vmrt_pkg::R_STATUS:      rsp.read_data = {28'd0, status_q};
				vmrt_pkg::R_QUEUE_MAX:
					rsp.read_data = qsel_nz_q ? 32'd0 : {16'd0, cfg.queue_size_required};
				vmrt_pkg::R_QUEUE_READY: rsp.read_data = {31'd0, !qsel_nz_q && qready_q};
				vmrt_pkg::R_INT_STATUS:  rsp.read_data = {31'd0, irq_q};
				vmrt_pkg::R_DEV_FEAT_SEL, vmrt_pkg::R_DRV_FEAT, vmrt_pkg::R_DRV_FEAT_SEL,
				vmrt_pkg::R_QUEUE_SEL, vmrt_pkg::R_QUEUE_SIZE, vmrt_pkg::R_QUEUE_NOTIFY,
				vmrt_pkg::R_INT_ACK, vmrt_pkg::R_DESC_LO, vmrt_pkg::R_DESC_HI,
				vmrt_pkg::R_DRV_LO, vmrt_pkg::R_DRV_HI, vmrt_pkg::R_DEV_LO,
				vmrt_pkg::R_DEV_HI:
					rsp.error_code = vmrt_pkg::E_DIR;
				default: rsp.error_code = vmrt_pkg::E_UNIMPL;
			endcase
		end else begin
			unique case (off) inside
				vmrt_pkg::R_DEV_FEAT_SEL: dfs_one_d = (v == 32'd1);
				vmrt_pkg::R_DRV_FEAT_SEL: begin
					if (status_q[vmrt_pkg::ST_FEAT_AGREED]) begin
						rsp.error_code = vmrt_pkg::E_REJECT;
					end else begin
						dsel_ge2_d = (v[31:1] != 31'd0);
						dsel_b0_d = v[0];
					end
				end
				vmrt_pkg::R_DRV_FEAT: begin
					if (status_q[vmrt_pkg::ST_FEAT_AGREED] || dsel_ge2_q) begin
						rsp.error_code = vmrt_pkg::E_REJECT;
					end else if (dsel_b0_q) begin
						w1_one_d = (v == 32'd1);
					end else begin
						w0_zero_d = (v == 32'd0);
					end
				end
				vmrt_pkg::R_QUEUE_SEL: qsel_nz_d = (v != 32'd0);
				vmrt_pkg::R_QUEUE_SIZE: begin
					if (qlock || v != {16'd0, cfg.queue_size_required}) begin
						rsp.error_code = vmrt_pkg::E_REJECT;
					end else begin
						qsize_d = v[15:0];
					end
				end
				vmrt_pkg::R_DESC_LO, vmrt_pkg::R_DESC_HI: begin
					if (qlock) rsp.error_code = vmrt_pkg::E_REJECT;
					else if (hi) desc_d[63:32] = v;
					else desc_d[31:0] = v;
				end
				vmrt_pkg::R_DRV_LO, vmrt_pkg::R_DRV_HI: begin
					if (qlock) rsp.error_code = vmrt_pkg::E_REJECT;
					else if (hi) avail_d[63:32] = v;
					else avail_d[31:0] = v;
				end
				vmrt_pkg::R_DEV_LO, vmrt_pkg::R_DEV_HI: begin
					if (qlock) rsp.error_code = vmrt_pkg::E_REJECT;
					else if (hi) used_d[63:32] = v;
					else used_d[31:0] = v;
				end
				vmrt_pkg::R_QUEUE_READY: begin
					if (qsel_nz_q || v[31:1] != 31'd0) begin
						rsp.error_code = vmrt_pkg::E_REJECT;
					end else if (!v[0]) begin
						qready_d = 1'b0;
					end else if (!layout_ok) begin
						rsp.error_code = vmrt_pkg::E_REJECT;
					end else begin
						qready_d = 1'b1;
					end
				end
				vmrt_pkg::R_QUEUE_NOTIFY: begin
					if (v != 32'd0 || status_q != vmrt_pkg::ST_ALL || !qready_q) begin
						rsp.error_code = vmrt_pkg::E_REJECT;
					end else begin
						rsp.notify_kick = 1'b1;
					end
				end
				vmrt_pkg::R_INT_ACK: begin
					if (v[31:1] != 31'd0) rsp.error_code = vmrt_pkg::E_REJECT;
					else irq_d = irq_q && !v[0];
				end
				vmrt_pkg::R_STATUS: begin
					if (v == 32'd0) begin
						// device reset: all transport state back to its reset value
						status_d = '0;
						dfs_one_d = 1'b0;
						dsel_ge2_d = 1'b0;
						dsel_b0_d = 1'b0;
						w0_zero_d = 1'b1;
						w1_one_d = 1'b0;
						qsel_nz_d = 1'b0;
						qsize_d = '0;
						qready_d = 1'b0;
						desc_d = '0;
						avail_d = '0;
						used_d = '0;
						irq_d = 1'b0;
					end else if (v[31:4] != 28'd0 || (v[3:0] & status_q) != status_q) begin
						rsp.error_code = vmrt_pkg::E_REJECT;
					end else begin
						if (v[vmrt_pkg::ST_FEAT_AGREED] && !status_q[vmrt_pkg::ST_FEAT_AGREED] &&
							fo_fail) begin
							st_acc[vmrt_pkg::ST_FEAT_AGREED] = 1'b0;
						end
						if (v[vmrt_pkg::ST_DRV_LIVE] && !status_q[vmrt_pkg::ST_DRV_LIVE] &&
							(!status_q[vmrt_pkg::ST_FEAT_AGREED] || !qready_q || !layout_ok)) begin
							rsp.error_code = vmrt_pkg::E_REJECT;
						end else begin
							status_d = st_acc;
						end
					end
				end
				vmrt_pkg::R_MAGIC, vmrt_pkg::R_VERSION, vmrt_pkg::R_DEVICE_ID,
				vmrt_pkg::R_VENDOR_ID, vmrt_pkg::R_DEV_FEAT, vmrt_pkg::R_QUEUE_MAX,
				vmrt_pkg::R_INT_STATUS:
					rsp.error_code = vmrt_pkg::E_DIR;
				default: rsp.error_code = vmrt_pkg::E_UNIMPL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			dfs_one_q <= 1'b0;
			dsel_ge2_q <= 1'b0;
			dsel_b0_q <= 1'b0;
			w0_zero_q <= 1'b1;
			w1_one_q <= 1'b0;
			qsel_nz_q <= 1'b0;
			qsize_q <= '0;
			qready_q <= 1'b0;
			desc_q <= '0;
			avail_q <= '0;
			used_q <= '0;
			irq_q <= 1'b0;
		end else if (advance) begin
			status_q <= status_d;
			dfs_one_q <= dfs_one_d;
			dsel_ge2_q <= dsel_ge2_d;
			dsel_b0_q <= dsel_b0_d;
			w0_zero_q <= w0_zero_d;
			w1_one_q <= w1_one_d;
			qsel_nz_q <= qsel_nz_d;
			qsize_q <= qsize_d;
			qready_q <= qready_d;
			desc_q <= desc_d;
			avail_q <= avail_d;
			used_q <= used_d;
			irq_q <= irq_d;
		end
	end

endmodule

[rtl/vmrt_rsp_stage.sv]
module vmrt_rsp_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  vmrt_pkg::rsp_t  rsp_in,
	output logic            can_load,
	output logic            out_valid,
	input  logic            out_ready,
	output vmrt_pkg::rsp_t  rsp_s2
);

	logic vld_s2;

	assign can_load = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (can_load) begin
			vld_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_s2 <= rsp_in;
		end
	end

	assign out_valid = vld_s2;

endmodule

[rtl/virtio_mmio_register_transport_top.sv]
// channel | dir | handshake   | payload
// req     | in  | valid/ready | func, offset, access_bytes, write_data
// rsp     | out | valid/ready | read_data, error_code, notify_kick
// cfg     | in  | cfg_we      | cfg_index, cfg_wdata (no read-back)
//
// One access per cycle sustained while rsp is not stalled.
// Access register -> decode/state update -> result register; the state update
// happens on the cycle the access moves into the result register.
// arst_n clears both stage valids and the transport state; config takes its defaults.
// A stalled rsp holds the result; req keeps flowing until the access register fills.
module virtio_mmio_register_transport_top (
	input  logic                            clk,
	input  logic                            arst_n,
	vmrt_req_if.sink                        req,
	vmrt_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [vmrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vmrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	vmrt_pkg::cfg_t cfg;
	vmrt_pkg::req_t req_in;
	vmrt_pkg::req_t req_s1;
	vmrt_pkg::rsp_t rsp_core;
	vmrt_pkg::rsp_t rsp_s2;
	logic           valid_s1;
	logic           can_load;
	logic           advance;

	// access moves into the result register when that register is free or draining
	assign advance = valid_s1 && can_load;

	assign req_in.func = req.func;
	assign req_in.offset = req.offset;
	assign req_in.access_bytes = req.access_bytes;
	assign req_in.write_data = req.write_data;

	vmrt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	vmrt_req_stage u_req (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_data  (req_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	// register decode, status rules and queue state
	vmrt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.cfg     (cfg),
		.rsp     (rsp_core)
	);

	vmrt_rsp_stage u_rsp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.rsp_in    (rsp_core),
		.can_load  (can_load),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.rsp_s2    (rsp_s2)
	);

	assign rsp.read_data = rsp_s2.read_data;
	assign rsp.error_code = rsp_s2.error_code;
	assign rsp.notify_kick = rsp_s2.notify_kick;

`ifndef SYNTHESIS
	// a kick is only raised by an accepted notify
	a_kick_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.notify_kick) |-> (rsp.error_code == vmrt_pkg::E_OK))
		else $error("kick with error code");

	// failed accesses return zero data
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.read_data != 32'd0) |-> (rsp.error_code == vmrt_pkg::E_OK))
		else $error("read data on failed access");

	// a held access stays in the access register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(req_s1)))
		else $error("access register lost a held access");

	// a new result is loaded only after the previous one has gone out
	a_s2_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten");
`endif

endmodule

[tb/virtio_mmio_register_transport_top_tb.sv]
`timescale 1ns / 100ps

module virtio_mmio_register_transport_top_tb;
	import vmrt_pkg::*;

	// watchdog: cycles in a row without any transfer on either channel
	localparam int STALL_LIMIT = 2000;
	localparam int SHOW_MAX = 10;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	vmrt_req_if req_ch ();
	vmrt_rsp_if rsp_ch ();

	virtio_mmio_register_transport_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Shadow of the transport: configuration plus the register state the
	// driver sees. Updated once per accepted access, in transfer order.
	// ------------------------------------------------------------------
	cfg_t        transport_cfg;
	logic [7:0]  dev_status;
	logic [31:0] dev_fsel;
	logic [31:0] drv_fsel;
	logic [31:0] drv_feat [2];
	logic [31:0] q_sel;
	logic [15:0] q_size;
	logic        q_ready;
	logic [63:0] q_desc;
	logic [63:0] q_avail;
	logic [63:0] q_used;
	logic        vring_irq;

	// outcomes of accepted accesses, oldest first
	rsp_t awaited_outcomes [$];

	int fail_cnt;
	int items_sent;
	int idle_cycles;

	// sender burst control and receiver stall pattern
	int          burst_left;
	bit          send_gaps_on;
	bit          rsp_stall_on;
	logic [12:0] stall_pattern;
	int          stall_phase;
	int          flip_odds;

	logic [8:0] reg_offsets [0:21] = '{
		R_MAGIC, R_VERSION, R_DEVICE_ID, R_VENDOR_ID, R_DEV_FEAT, R_DEV_FEAT_SEL,
		R_DRV_FEAT, R_DRV_FEAT_SEL, R_QUEUE_SEL, R_QUEUE_MAX, R_QUEUE_SIZE,
		R_QUEUE_READY, R_QUEUE_NOTIFY, R_INT_STATUS, R_INT_ACK, R_STATUS,
		R_DESC_LO, R_DESC_HI, R_DRV_LO, R_DRV_HI, R_DEV_LO, R_DEV_HI
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_device_state();
		dev_status = '0;
		dev_fsel = '0;
		drv_fsel = '0;
		drv_feat[0] = '0;
		drv_feat[1] = '0;
		q_sel = '0;
		q_size = '0;
		q_ready = 1'b0;
		q_desc = '0;
		q_avail = '0;
		q_used = '0;
		vring_irq = 1'b0;
	endfunction

	function automatic bit layout_matches();
		return q_size == transport_cfg.queue_size_required &&
			q_desc == transport_cfg.desc_ring_addr &&
			q_avail == transport_cfg.avail_ring_addr &&
			q_used == transport_cfg.used_ring_addr;
	endfunction

	// Works out the reply to one access and applies its side effects.
	function automatic rsp_t mmio_access_outcome(req_t a);
		rsp_t r;
		logic [31:0] v;
		logic [31:0] old_status;
		logic [31:0] accepted;
		bit qlock;
		r = '0;
		v = a.write_data;
		old_status = {24'b0, dev_status};
		qlock = (q_sel != 0) || q_ready;
		if (a.func == FN_DONE) begin
			// completion ignores offset, length and data
			vring_irq = 1'b1;
		end else if (a.func != FN_READ && a.func != FN_WRITE) begin
			r.error_code = E_DIR;
		end else if (a.access_bytes != ACCESS_LEN || a.offset[1:0] != 2'b00 ||
				a.offset > OFF_LAST) begin
			r.error_code = E_ACCESS;
		end else if (a.func == FN_READ) begin
			case (a.offset)
				R_MAGIC: r.read_data = MAGIC_VALUE;
				R_VERSION: r.read_data = VERSION_MODERN;
				R_DEVICE_ID: r.read_data = transport_cfg.device_id;
				R_VENDOR_ID: r.read_data = transport_cfg.vendor_id;
				// only word 1 carries a feature: the modern-device bit
				R_DEV_FEAT: r.read_data = (dev_fsel == 32'd1) ? 32'd1 : 32'd0;
				R_STATUS: r.read_data = old_status;
				R_QUEUE_MAX: r.read_data = (q_sel == 0) ?
					32'(transport_cfg.queue_size_required) : 32'd0;
				R_QUEUE_READY: r.read_data = {31'b0, q_ready && (q_sel == 0)};
				R_INT_STATUS: r.read_data = {31'b0, vring_irq};
				R_DEV_FEAT_SEL, R_DRV_FEAT, R_DRV_FEAT_SEL, R_QUEUE_SEL, R_QUEUE_SIZE,
				R_QUEUE_NOTIFY, R_INT_ACK, R_DESC_LO, R_DESC_HI, R_DRV_LO, R_DRV_HI,
				R_DEV_LO, R_DEV_HI: r.error_code = E_DIR;
				default: r.error_code = E_UNIMPL;
			endcase
		end else begin
			case (a.offset)
				R_DEV_FEAT_SEL: dev_fsel = v;
				R_DRV_FEAT_SEL: begin
					if (dev_status[ST_FEAT_AGREED]) r.error_code = E_REJECT;
					else drv_fsel = v;
				end
				R_DRV_FEAT: begin
					if (dev_status[ST_FEAT_AGREED] || drv_fsel >= 2) r.error_code = E_REJECT;
					else drv_feat[drv_fsel[0]] = v;
				end
				R_QUEUE_SEL: q_sel = v;
				R_QUEUE_SIZE: begin
					if (qlock || v != 32'(transport_cfg.queue_size_required))
						r.error_code = E_REJECT;
					else q_size = v[15:0];
				end
				R_DESC_LO, R_DESC_HI, R_DRV_LO, R_DRV_HI, R_DEV_LO, R_DEV_HI: begin
					if (qlock) r.error_code = E_REJECT;
					else if (a.offset == R_DESC_LO) q_desc[31:0] = v;
					else if (a.offset == R_DESC_HI) q_desc[63:32] = v;
					else if (a.offset == R_DRV_LO) q_avail[31:0] = v;
					else if (a.offset == R_DRV_HI) q_avail[63:32] = v;
					else if (a.offset == R_DEV_LO) q_used[31:0] = v;
					else q_used[63:32] = v;
				end
				R_QUEUE_READY: begin
					if (q_sel != 0 || v > 1) r.error_code = E_REJECT;
					else if (v == 0) q_ready = 1'b0;
					else if (!layout_matches()) r.error_code = E_REJECT;
					else q_ready = 1'b1;
				end
				R_QUEUE_NOTIFY: begin
					if (v != 0 || old_status != {28'b0, ST_ALL} || !q_ready)
						r.error_code = E_REJECT;
					else r.notify_kick = 1'b1;
				end
				R_INT_ACK: begin
					if (v[31:1] != 0) r.error_code = E_REJECT;
					else if (v[0]) vring_irq = 1'b0;
				end
				R_STATUS: begin
					if (v == 0) begin
						clear_device_state();
					end else if ((v & ~{28'b0, ST_ALL}) != 0 ||
							(v & old_status) != old_status) begin
						// unknown bits, or an attempt to take a bit back
						r.error_code = E_REJECT;
					end else begin
						accepted = v;
						// the features-agreed bit is silently dropped when negotiation fails
						if (v[ST_FEAT_AGREED] && !dev_status[ST_FEAT_AGREED] &&
								(!v[ST_ACK] || !v[ST_DRIVER] ||
								drv_feat[0] != 0 || drv_feat[1] != 1))
							accepted[ST_FEAT_AGREED] = 1'b0;
						// going live needs features already agreed, a ready queue and a matching layout
						if (v[ST_DRV_LIVE] && !dev_status[ST_DRV_LIVE] &&
								(!dev_status[ST_FEAT_AGREED] || !q_ready || !layout_matches()))
							r.error_code = E_REJECT;
						else
							dev_status = accepted[7:0];
					end
				end
				R_MAGIC, R_VERSION, R_DEVICE_ID, R_VENDOR_ID, R_DEV_FEAT, R_QUEUE_MAX,
				R_INT_STATUS: r.error_code = E_DIR;
				default: r.error_code = E_UNIMPL;
			endcase
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Receiver: with stalls on, ready follows a 13-bit stall pattern,
	// reshuffled now and then, so stalls drift across the sender's bursts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_ch.ready <= rsp_stall_on ? stall_pattern[stall_phase] : 1'b1;
		if (stall_phase == 12) begin
			stall_phase <= 0;
			if ($urandom_range(0, 3) == 0) stall_pattern <= 13'($urandom) | 13'h1;
		end else begin
			stall_phase <= stall_phase + 1;
		end
	end

	// Result checker: every response transfer must match the oldest outcome.
	always @(posedge clk) begin : result_check
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.read_data = rsp_ch.read_data;
			got.error_code = rsp_ch.error_code;
			got.notify_kick = rsp_ch.notify_kick;
			if (awaited_outcomes.size() == 0) begin
				if (fail_cnt < SHOW_MAX)
					$display("%0t: response with nothing outstanding: rd=%h err=%0d kick=%b",
						$realtime, got.read_data, got.error_code, got.notify_kick);
				fail_cnt++;
			end else begin
				want = awaited_outcomes.pop_front();
				if (got.read_data !== want.read_data || got.error_code !== want.error_code ||
						got.notify_kick !== want.notify_kick) begin
					if (fail_cnt < SHOW_MAX)
						$display("%0t: mismatch: exp rd=%h err=%0d kick=%b, got rd=%h err=%0d kick=%b",
							$realtime, want.read_data, want.error_code, want.notify_kick,
							got.read_data, got.error_code, got.notify_kick);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sender. Called and returns at a rising edge; valid stays up across
	// back-to-back items and only drops for a gap between bursts.
	// ------------------------------------------------------------------
	task automatic send_access(input logic [1:0] fn, input logic [8:0] off,
			input logic [3:0] len, input logic [31:0] data);
		req_t item;
		item.func = fn;
		item.offset = off;
		item.access_bytes = len;
		item.write_data = data;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (send_gaps_on) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.offset <= off;
		req_ch.access_bytes <= len;
		req_ch.write_data <= data;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		// transfer at this edge
		awaited_outcomes.push_back(mmio_access_outcome(item));
		items_sent++;
	endtask

	task automatic reg_read(input logic [8:0] off);
		send_access(FN_READ, off, ACCESS_LEN, $urandom);
	endtask

	task automatic reg_write(input logic [8:0] off, input logic [31:0] data);
		send_access(FN_WRITE, off, ACCESS_LEN, data);
	endtask

	// Drop valid and hold off until every outstanding reply has come back.
	task automatic await_all_results();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// cfg_we stays high across consecutive writes; caller lowers it.
	task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_DEVICE_ID: transport_cfg.device_id = val[31:0];
			CFG_VENDOR_ID: transport_cfg.vendor_id = val[31:0];
			CFG_QUEUE_SIZE: transport_cfg.queue_size_required = val[15:0];
			CFG_DESC_ADDR: transport_cfg.desc_ring_addr = val;
			CFG_AVAIL_ADDR: transport_cfg.avail_ring_addr = val;
			CFG_USED_ADDR: transport_cfg.used_ring_addr = val;
			default: ;
		endcase
	endtask

	task automatic apply_config(input cfg_t c);
		write_cfg_reg(CFG_DEVICE_ID, 64'(c.device_id));
		write_cfg_reg(CFG_VENDOR_ID, 64'(c.vendor_id));
		write_cfg_reg(CFG_QUEUE_SIZE, 64'(c.queue_size_required));
		write_cfg_reg(CFG_DESC_ADDR, c.desc_ring_addr);
		write_cfg_reg(CFG_AVAIL_ADDR, c.avail_ring_addr);
		write_cfg_reg(CFG_USED_ADDR, c.used_ring_addr);
		cfg_we <= 1'b0;
	endtask

	// Data words biased toward values the registers care about.
	function automatic logic [31:0] noise_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'd0;
			2: return 32'd1;
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	// The intended value, or now and then a corrupted one.
	function automatic logic [31:0] mostly(input logic [31:0] good);
		if (flip_odds != 0 && $urandom_range(0, flip_odds - 1) == 0) return noise_word();
		return good;
	endfunction

	task automatic noise_access();
		int pick;
		logic [1:0] fn;
		logic [8:0] off;
		logic [3:0] len;
		pick = $urandom_range(0, 9);
		if (pick < 4) fn = FN_READ;
		else if (pick < 8) fn = FN_WRITE;
		else if (pick == 8) fn = FN_DONE;
		else fn = 2'($urandom_range(0, 3));
		off = ($urandom_range(0, 4) == 0) ? 9'($urandom) : reg_offsets[$urandom_range(0, 21)];
		len = ($urandom_range(0, 7) == 0) ? 4'($urandom) : ACCESS_LEN;
		send_access(fn, off, len, noise_word());
	endtask

	// Driver bring-up as the spec orders it, then some queue traffic. With
	// flip_odds set, single steps get corrupted to poke the rejection paths.
	task automatic drive_bringup();
		if ($urandom_range(0, 5) != 0) reg_write(R_STATUS, 32'd0);
		reg_write(R_STATUS, mostly(32'd1));
		reg_write(R_STATUS, mostly(32'd3));
		reg_write(R_DEV_FEAT_SEL, mostly(32'd1));
		reg_read(R_DEV_FEAT);
		reg_write(R_DRV_FEAT_SEL, mostly(32'd0));
		reg_write(R_DRV_FEAT, mostly(32'd0));
		reg_write(R_DRV_FEAT_SEL, mostly(32'd1));
		reg_write(R_DRV_FEAT, mostly(32'd1));
		reg_write(R_STATUS, mostly(32'd11));
		reg_read(R_STATUS);
		reg_write(R_QUEUE_SEL, mostly(32'd0));
		reg_read(R_QUEUE_MAX);
		reg_write(R_QUEUE_SIZE, mostly(32'(transport_cfg.queue_size_required)));
		reg_write(R_DESC_LO, mostly(transport_cfg.desc_ring_addr[31:0]));
		reg_write(R_DESC_HI, mostly(transport_cfg.desc_ring_addr[63:32]));
		reg_write(R_DRV_LO, mostly(transport_cfg.avail_ring_addr[31:0]));
		reg_write(R_DRV_HI, mostly(transport_cfg.avail_ring_addr[63:32]));
		reg_write(R_DEV_LO, mostly(transport_cfg.used_ring_addr[31:0]));
		reg_write(R_DEV_HI, mostly(transport_cfg.used_ring_addr[63:32]));
		reg_write(R_QUEUE_READY, mostly(32'd1));
		reg_read(R_QUEUE_READY);
		reg_write(R_STATUS, mostly(32'd15));
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 4))
				0: reg_write(R_QUEUE_NOTIFY, mostly(32'd0));
				1: send_access(FN_DONE, 9'($urandom), 4'($urandom), $urandom);
				2: reg_read(R_INT_STATUS);
				3: reg_write(R_INT_ACK, mostly(32'd1));
				default: reg_read(R_STATUS);
			endcase
		end
	endtask

	// Mostly well-formed bring-ups (half clean, half corrupted), rest noise.
	task automatic run_random(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) < 6) begin
				flip_odds = $urandom_range(0, 1) ? 0 : 8;
				drive_bringup();
			end else begin
				repeat ($urandom_range(1, 6)) noise_access();
			end
		end
	endtask

	task automatic run_phase(input cfg_t setting, input int n, input bit gaps, input bit stalls);
		await_all_results();
		apply_config(setting);
		send_gaps_on = gaps;
		rsp_stall_on = stalls;
		run_random(n);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Identity reads, direction and decode errors, malformed accesses,
	// unknown function, completion and interrupt acknowledge.
	task automatic test_decode_corners();
		reg_read(R_MAGIC);
		reg_read(R_VERSION);
		reg_read(R_DEVICE_ID);
		reg_read(R_VENDOR_ID);
		reg_read(R_DEV_FEAT);
		reg_read(R_QUEUE_MAX);
		reg_read(R_STATUS);
		reg_read(R_INT_STATUS);
		reg_read(R_QUEUE_READY);
		reg_read(R_DRV_FEAT);               // write-only
		reg_write(R_MAGIC, 32'hffff_ffff);  // read-only
		reg_read(9'h1fc);                   // last word, nothing mapped
		reg_write(9'h0fc, 32'h0);
		send_access(FN_READ, R_MAGIC, 4'd0, 32'h0);
		send_access(FN_READ, R_MAGIC, 4'd15, 32'h0);
		send_access(FN_WRITE, 9'h002, ACCESS_LEN, 32'h0);   // misaligned
		send_access(FN_READ, 9'h1ff, ACCESS_LEN, 32'h0);
		send_access(2'($urandom_range(3, 3)), R_MAGIC, ACCESS_LEN, 32'h0);
		send_access(FN_DONE, 9'h1ff, 4'hf, 32'hffff_ffff);  // fields ignored
		reg_read(R_INT_STATUS);
		reg_write(R_INT_ACK, 32'd2);
		reg_write(R_INT_ACK, 32'hffff_ffff);
		reg_write(R_INT_ACK, 32'd1);
		reg_write(R_STATUS, 32'h10);
		reg_write(R_QUEUE_NOTIFY, 32'd0);   // device not live yet
		reg_write(R_STATUS, 32'd0);
	endtask

	// Clean bring-up at reset configuration, kick, interrupt round trip,
	// then the queue locks and the status-zero reset.
	task automatic test_driver_bringup();
		flip_odds = 0;
		drive_bringup();
		reg_write(R_QUEUE_NOTIFY, 32'd0);
		reg_write(R_QUEUE_NOTIFY, 32'd1);
		send_access(FN_DONE, 9'h0, 4'h0, 32'h0);
		reg_read(R_INT_STATUS);
		reg_write(R_INT_ACK, 32'd1);
		reg_read(R_INT_STATUS);
		reg_write(R_DESC_LO, 32'h0);        // locked while ready
		reg_write(R_QUEUE_READY, 32'd2);
		reg_write(R_STATUS, 32'd3);         // taking bits back
		reg_write(R_QUEUE_READY, 32'd0);
		reg_write(R_QUEUE_SEL, 32'd1);
		reg_read(R_QUEUE_MAX);
		reg_read(R_QUEUE_READY);
		reg_write(R_QUEUE_SIZE, 32'd8);     // locked by the selector
		reg_write(R_STATUS, 32'd0);
		reg_read(R_STATUS);
	endtask

	// Several configurations, the extremes among them, each with random
	// traffic and a chosen idling mix. Each change waits for the bus to drain.
	task automatic test_config_sweep();
		cfg_t setting;

		setting.device_id = 32'd4;
		setting.vendor_id = 32'd0;
		setting.queue_size_required = 16'd8;
		setting.desc_ring_addr = 64'h4000;
		setting.avail_ring_addr = 64'h5000;
		setting.used_ring_addr = 64'h6000;
		run_phase(setting, 130, 1'b0, 1'b0);   // full rate both sides

		setting.device_id = '0;
		setting.vendor_id = '0;
		setting.queue_size_required = 16'd1;
		setting.desc_ring_addr = '0;
		setting.avail_ring_addr = '0;
		setting.used_ring_addr = '0;
		run_phase(setting, 130, 1'b1, 1'b1);

		setting.device_id = '1;
		setting.vendor_id = '1;
		setting.queue_size_required = 16'h8000;
		setting.desc_ring_addr = '1;
		setting.avail_ring_addr = '1;
		setting.used_ring_addr = '1;
		run_phase(setting, 130, 1'b1, 1'b0);

		setting.device_id = $urandom;
		setting.vendor_id = $urandom;
		setting.queue_size_required = 16'($urandom_range(1, 32768));
		setting.desc_ring_addr = {$urandom, $urandom};
		setting.avail_ring_addr = {$urandom, $urandom};
		setting.used_ring_addr = {$urandom, $urandom};
		run_phase(setting, 130, 1'b0, 1'b1);

		setting.device_id = 32'd4;
		setting.vendor_id = 32'd0;
		setting.queue_size_required = 16'd8;
		setting.desc_ring_addr = 64'h4000;
		setting.avail_ring_addr = 64'h5000;
		setting.used_ring_addr = 64'h6000;
		run_phase(setting, 130, 1'b1, 1'b1);
	endtask

	initial begin
		// all inputs known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_READ;
		req_ch.offset = '0;
		req_ch.access_bytes = '0;
		req_ch.write_data = '0;
		rsp_ch.ready = 1'b0;
		stall_pattern = 13'h1b5d;
		stall_phase = 0;
		rsp_stall_on = 1'b1;
		send_gaps_on = 1'b1;
		burst_left = 0;
		flip_odds = 0;
		fail_cnt = 0;
		items_sent = 0;
		idle_cycles = 0;

		// configuration comes out of reset at its defaults
		transport_cfg.device_id = 32'd4;
		transport_cfg.vendor_id = 32'd0;
		transport_cfg.queue_size_required = 16'd8;
		transport_cfg.desc_ring_addr = 64'h4000;
		transport_cfg.avail_ring_addr = 64'h5000;
		transport_cfg.used_ring_addr = 64'h6000;
		clear_device_state();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_decode_corners();
		test_driver_bringup();
		test_config_sweep();

		await_all_results();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && awaited_outcomes.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
